// File: rtl/prtc_pkg.sv
// ----------------------------------------------------------------------------
// prtc_pkg
// shared types and constants of the pulse rate threshold counter
// ----------------------------------------------------------------------------
package prtc_pkg;

    localparam int CALIBRATION_SAMPLES_DEF = 10;

    localparam int SAMPLE_W = 10;
    localparam int LEVEL_W  = 11;
    localparam int SUM_W    = 16;
    localparam int INDEX_W  = 8;
    localparam int RATE_W   = 10;
    localparam int CLASS_W  = 2;
    localparam int PULSE_W  = 8;
    localparam int PROD_W   = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_OFFSET = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MEASURE_SAMPLES  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BPM_PER_PULSE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RATE_FLOOR       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RATE_CEILING     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_LOW       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_HIGH      = 3'd6;

    localparam logic [9:0] RST_THRESHOLD_OFFSET = 10'd50;
    localparam logic [7:0] RST_MEASURE_SAMPLES  = 8'd60;
    localparam logic [7:0] RST_BPM_PER_PULSE    = 8'd20;
    localparam logic [9:0] RST_RATE_FLOOR       = 10'd60;
    localparam logic [9:0] RST_RATE_CEILING     = 10'd150;
    localparam logic [9:0] RST_NORMAL_LOW       = 10'd60;
    localparam logic [9:0] RST_NORMAL_HIGH      = 10'd100;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_LOW    = 2'd0,
        CLASS_NORMAL = 2'd1,
        CLASS_HIGH   = 2'd2
    } t_rate_class;

    typedef struct packed {
        logic [9:0] threshold_offset;
        logic [7:0] measure_samples;
        logic [7:0] bpm_per_pulse;
        logic [9:0] rate_floor;
        logic [9:0] rate_ceiling;
        logic [9:0] normal_low;
        logic [9:0] normal_high;
    } t_cfg;

    typedef struct packed {
        logic                valid;
        logic [RATE_W-1:0]   rate;
        t_rate_class         rate_class;
        logic [PULSE_W-1:0]  pulses;
    } t_result;

endpackage

// File: rtl/prtc_cfg.sv
// ----------------------------------------------------------------------------
// prtc_cfg
// configuration register file, one register written per request
// ----------------------------------------------------------------------------
module prtc_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [prtc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [prtc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output prtc_pkg::t_cfg                    o_cfg
);

    prtc_pkg::t_cfg r_cfg;
    prtc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                prtc_pkg::REG_THRESHOLD_OFFSET: n_cfg.threshold_offset = i_cfg_data;
                prtc_pkg::REG_MEASURE_SAMPLES:  n_cfg.measure_samples  = i_cfg_data[7:0];
                prtc_pkg::REG_BPM_PER_PULSE:    n_cfg.bpm_per_pulse    = i_cfg_data[7:0];
                prtc_pkg::REG_RATE_FLOOR:       n_cfg.rate_floor       = i_cfg_data;
                prtc_pkg::REG_RATE_CEILING:     n_cfg.rate_ceiling     = i_cfg_data;
                prtc_pkg::REG_NORMAL_LOW:       n_cfg.normal_low       = i_cfg_data;
                prtc_pkg::REG_NORMAL_HIGH:      n_cfg.normal_high      = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_offset <= prtc_pkg::RST_THRESHOLD_OFFSET;
            r_cfg.measure_samples  <= prtc_pkg::RST_MEASURE_SAMPLES;
            r_cfg.bpm_per_pulse    <= prtc_pkg::RST_BPM_PER_PULSE;
            r_cfg.rate_floor       <= prtc_pkg::RST_RATE_FLOOR;
            r_cfg.rate_ceiling     <= prtc_pkg::RST_RATE_CEILING;
            r_cfg.normal_low       <= prtc_pkg::RST_NORMAL_LOW;
            r_cfg.normal_high      <= prtc_pkg::RST_NORMAL_HIGH;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/prtc_core.sv
// ----------------------------------------------------------------------------
// prtc_core
// calibration and crossing-count state, window result logic
// ----------------------------------------------------------------------------
module prtc_core #(
    parameter int CALIBRATION_SAMPLES = prtc_pkg::CALIBRATION_SAMPLES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  prtc_pkg::t_cfg                  i_cfg,
    input  logic                            i_step,
    input  logic [prtc_pkg::SAMPLE_W-1:0]   i_sample,
    output prtc_pkg::t_result               o_result
);

    // average by reciprocal multiply, exact for every 16-bit sum
    localparam int DIV_SHIFT = prtc_pkg::SUM_W + $clog2(CALIBRATION_SAMPLES);
    localparam int MULT_W    = prtc_pkg::SUM_W + 1;
    localparam int DPROD_W   = prtc_pkg::SUM_W + MULT_W;
    localparam logic [MULT_W-1:0] DIV_MULT = MULT_W'(
        ((64'd1 << DIV_SHIFT) + 64'(CALIBRATION_SAMPLES) - 64'd1)
        / 64'(CALIBRATION_SAMPLES));
    localparam logic [prtc_pkg::INDEX_W-1:0] CAL_COUNT =
        prtc_pkg::INDEX_W'(CALIBRATION_SAMPLES);

    logic                            r_measuring;
    logic [prtc_pkg::INDEX_W-1:0]    r_sample_index;
    logic [prtc_pkg::SUM_W-1:0]      r_calibration_sum;
    logic [prtc_pkg::LEVEL_W-1:0]    r_detect_level;
    logic                            r_was_above;
    logic [prtc_pkg::PULSE_W-1:0]    r_pulse_tally;

    logic                            n_measuring;
    logic [prtc_pkg::INDEX_W-1:0]    n_sample_index;
    logic [prtc_pkg::SUM_W-1:0]      n_calibration_sum;
    logic [prtc_pkg::LEVEL_W-1:0]    n_detect_level;
    logic                            n_was_above;
    logic [prtc_pkg::PULSE_W-1:0]    n_pulse_tally;

    logic [prtc_pkg::INDEX_W-1:0]    idx_inc;
    logic [prtc_pkg::SUM_W-1:0]      sum_inc;
    logic [DPROD_W-1:0]              div_prod;
    logic [prtc_pkg::SUM_W-1:0]      avg;
    logic                            above;
    logic [prtc_pkg::PULSE_W-1:0]    tally_inc;
    logic                            window_end;
    logic [prtc_pkg::PROD_W-1:0]     raw_rate;
    logic [prtc_pkg::RATE_W-1:0]     clamped;

    always_comb begin
        idx_inc   = r_sample_index + prtc_pkg::INDEX_W'(1);
        sum_inc   = r_calibration_sum + prtc_pkg::SUM_W'(i_sample);
        div_prod  = DPROD_W'(sum_inc) * DPROD_W'(DIV_MULT);
        avg       = prtc_pkg::SUM_W'(div_prod >> DIV_SHIFT);
        above     = prtc_pkg::LEVEL_W'(i_sample) > r_detect_level;
        tally_inc = (above && !r_was_above) ? r_pulse_tally + prtc_pkg::PULSE_W'(1)
                                            : r_pulse_tally;
        window_end = r_measuring && !(idx_inc < i_cfg.measure_samples);

        raw_rate = prtc_pkg::PROD_W'(tally_inc) * prtc_pkg::PROD_W'(i_cfg.bpm_per_pulse);
        if (raw_rate < prtc_pkg::PROD_W'(i_cfg.rate_floor)) begin
            clamped = i_cfg.rate_floor;
        end else if (raw_rate > prtc_pkg::PROD_W'(i_cfg.rate_ceiling)) begin
            clamped = i_cfg.rate_ceiling;
        end else begin
            clamped = raw_rate[prtc_pkg::RATE_W-1:0];
        end

        o_result.valid  = window_end;
        o_result.rate   = clamped;
        o_result.pulses = tally_inc;
        if (clamped >= i_cfg.normal_low && clamped <= i_cfg.normal_high) begin
            o_result.rate_class = prtc_pkg::CLASS_NORMAL;
        end else if (clamped > i_cfg.normal_high) begin
            o_result.rate_class = prtc_pkg::CLASS_HIGH;
        end else begin
            o_result.rate_class = prtc_pkg::CLASS_LOW;
        end

        n_measuring       = r_measuring;
        n_sample_index    = idx_inc;
        n_calibration_sum = r_calibration_sum;
        n_detect_level    = r_detect_level;
        n_was_above       = r_was_above;
        n_pulse_tally     = r_pulse_tally;

        if (!r_measuring) begin
            n_calibration_sum = sum_inc;
            if (idx_inc >= CAL_COUNT) begin
                n_detect_level    = prtc_pkg::LEVEL_W'(avg)
                                  + prtc_pkg::LEVEL_W'(i_cfg.threshold_offset);
                n_measuring       = 1'b1;
                n_sample_index    = '0;
                n_calibration_sum = '0;
                n_was_above       = 1'b0;
                n_pulse_tally     = '0;
            end
        end else if (window_end) begin
            n_measuring       = 1'b0;
            n_sample_index    = '0;
            n_calibration_sum = '0;
            n_was_above       = 1'b0;
            n_pulse_tally     = '0;
        end else begin
            n_was_above   = above;
            n_pulse_tally = tally_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_measuring       <= 1'b0;
            r_sample_index    <= '0;
            r_calibration_sum <= '0;
            r_detect_level    <= '0;
            r_was_above       <= 1'b0;
            r_pulse_tally     <= '0;
        end else if (i_step) begin
            r_measuring       <= n_measuring;
            r_sample_index    <= n_sample_index;
            r_calibration_sum <= n_calibration_sum;
            r_detect_level    <= n_detect_level;
            r_was_above       <= n_was_above;
            r_pulse_tally     <= n_pulse_tally;
        end
    end

endmodule

// File: rtl/pulse_rate_threshold_counter.sv
// ----------------------------------------------------------------------------
// pulse_rate_threshold_counter
// threshold-crossing pulse counter with calibration, clamp and rate class
// ----------------------------------------------------------------------------
// One sample is taken per clock while the input side does not stall. A
// sample lands in an input register; when the core steps on it, a result
// that closes a window is written to the output register. The input side
// stalls only while the output register still holds an untaken result and
// the sample in the input register closes the next window. Each run starts
// with CALIBRATION_SAMPLES samples that set the threshold, then
// measure_samples samples are counted; the user must write registers through
// the configuration channel only while no sample is in flight, which the block itself does not enforce.
module pulse_rate_threshold_counter #(
    parameter int CALIBRATION_SAMPLES = prtc_pkg::CALIBRATION_SAMPLES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,   // sample[9:0]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [23:0] m_axis_tdata,   // rate[9:0], rate_class[11:10], pulses[19:12]
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [prtc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [prtc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    prtc_pkg::t_cfg                  cfg;
    prtc_pkg::t_result               result;

    logic                            r_in_valid;
    logic [prtc_pkg::SAMPLE_W-1:0]   r_sample;
    logic                            r_out_valid;
    logic [prtc_pkg::RATE_W-1:0]     r_rate;
    prtc_pkg::t_rate_class           r_rate_class;
    logic [prtc_pkg::PULSE_W-1:0]    r_pulses;
    logic                            step;

    assign o_cfg_ready = 1'b1;

    prtc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    prtc_core #(
        .CALIBRATION_SAMPLES (CALIBRATION_SAMPLES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (step),
        .i_sample (r_sample),
        .o_result (result)
    );

    assign step          = r_in_valid && (!result.valid || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_sample <= s_axis_tdata[prtc_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && result.valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && result.valid) begin
            r_rate       <= result.rate;
            r_rate_class <= result.rate_class;
            r_pulses     <= result.pulses;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_pulses, r_rate_class, r_rate};

endmodule
